>>> hdl/slfr_pkg.sv
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared widths, register indexes, reset values and control/status structs
// for the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam int PAYLOAD_DEPTH_DEF = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 2'd3;

	// register reset values
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h33;
	localparam logic [BYTE_W-1:0] RESERVED_RST    = 8'h00;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST     = 7'd64;

	// controller -> datapath
	typedef struct packed {
		logic clear_cnt;   // count back to zero
		logic load_len;    // latch length byte
		logic write_byte;  // store payload byte at count
		logic inc_cnt;     // count + 1
		logic load_empty;  // output reg <- empty-frame beat
		logic load_data;   // output reg <- store read data
	} slfr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sync1_hit;
		logic sync2_hit;
		logic len_ok;
		logic rsv_hit;
		logic len_zero;
		logic cnt_last;    // count + 1 == expected length
		logic out_free;    // output reg can take a beat this cycle
	} slfr_stat_t;

endpackage

>>> hdl/slfr_ram.sv
// ----------------------------------------------------------------------------
// slfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/slfr_ctrl.sv
// ----------------------------------------------------------------------------
// slfr_ctrl
// Frame hunt / payload / readout state machine.
// ----------------------------------------------------------------------------
module slfr_ctrl
	import slfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  slfr_stat_t stat,
	output slfr_cmd_t  cmd
);

	localparam logic [2:0] S_SYNC1 = 3'd0;
	localparam logic [2:0] S_SYNC2 = 3'd1;
	localparam logic [2:0] S_LEN   = 3'd2;
	localparam logic [2:0] S_RSV   = 3'd3;
	localparam logic [2:0] S_PAY   = 3'd4;
	localparam logic [2:0] S_RD    = 3'd5;  // read address presented
	localparam logic [2:0] S_LD    = 3'd6;  // read data into output reg

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       in_fire;

	assign in_fire = in_valid && in_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_SYNC1: begin
				in_ready = 1'b1;
				if (in_fire && stat.sync1_hit) begin
					state_d = S_SYNC2;
				end
			end
			S_SYNC2: begin
				in_ready = 1'b1;
				if (in_fire) begin
					// a bad second sync is dropped, not rechecked as a first sync
					if (stat.sync2_hit) begin
						state_d = S_LEN;
					end else begin
						cmd.clear_cnt = 1'b1;
						state_d       = S_SYNC1;
					end
				end
			end
			S_LEN: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.clear_cnt = 1'b1;
					if (stat.len_ok) begin
						cmd.load_len = 1'b1;
						state_d      = S_RSV;
					end else begin
						state_d = S_SYNC1;
					end
				end
			end
			S_RSV: begin
				// may emit the empty-frame beat
				in_ready = stat.out_free;
				if (in_fire) begin
					if (!stat.rsv_hit) begin
						cmd.clear_cnt = 1'b1;
						state_d       = S_SYNC1;
					end else if (stat.len_zero) begin
						cmd.load_empty = 1'b1;
						cmd.clear_cnt  = 1'b1;
						state_d        = S_SYNC1;
					end else begin
						state_d = S_PAY;
					end
				end
			end
			S_PAY: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.write_byte = 1'b1;
					if (stat.cnt_last) begin
						cmd.clear_cnt = 1'b1;
						state_d       = S_RD;
					end else begin
						cmd.inc_cnt = 1'b1;
					end
				end
			end
			S_RD: begin
				if (stat.out_free) begin
					state_d = S_LD;
				end
			end
			S_LD: begin
				cmd.load_data = 1'b1;
				if (stat.cnt_last) begin
					cmd.clear_cnt = 1'b1;
					state_d       = S_SYNC1;
				end else begin
					cmd.inc_cnt = 1'b1;
					state_d     = S_RD;
				end
			end
			default: begin
				cmd.clear_cnt = 1'b1;
				state_d       = S_SYNC1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SYNC1;
		end else begin
			state_q <= state_d;
		end
	end

	// readout never overlaps input
	a_no_in_during_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_LD) |-> !in_ready)
		else $error("input taken during readout");

	a_ld_follows_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LD) |-> $past(state_q) == S_RD)
		else $error("load without read cycle");

endmodule

>>> hdl/slfr_dp.sv
// ----------------------------------------------------------------------------
// slfr_dp
// Config registers, length/count, payload store and output register.
// ----------------------------------------------------------------------------
module slfr_dp
	import slfr_pkg::*;
#(
	parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  slfr_cmd_t            cmd,
	output slfr_stat_t           stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    out_byte,
	output logic [LEN_W-1:0]     frame_len,
	output logic                 empty_frame,
	output logic                 last
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam logic [BYTE_W-1:0] DEPTH_B = BYTE_W'(PAYLOAD_DEPTH);

	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	logic [BYTE_W-1:0] reserved_q;
	logic [LEN_W-1:0]  max_len_q;

	logic [LEN_W-1:0]  exp_len_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  cnt_inc;
	logic [LEN_W:0]    cnt_ext;
	logic [AW-1:0]     addr;
	logic [BYTE_W-1:0] max_ext;
	logic [BYTE_W-1:0] limit;
	logic [BYTE_W-1:0] rd_data;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [LEN_W-1:0]  frame_len_q;
	logic              empty_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			reserved_q    <= RESERVED_RST;
			max_len_q     <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				REG_RESERVED:    reserved_q    <= cfg_data;
				REG_MAX_LEN:     max_len_q     <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// length limit is min(max_payload_len, store depth)
	assign max_ext = {1'b0, max_len_q};
	assign limit   = (max_ext > DEPTH_B) ? DEPTH_B : max_ext;

	assign cnt_inc = cnt_q + 1'b1;
	assign cnt_ext = {1'b0, cnt_q};
	assign addr    = cnt_ext[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.load_len) begin
				exp_len_q <= rx_byte[LEN_W-1:0];
			end
			if (cmd.clear_cnt) begin
				cnt_q <= '0;
			end else if (cmd.inc_cnt) begin
				cnt_q <= cnt_inc;
			end
		end
	end

	slfr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(PAYLOAD_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.write_byte),
		.waddr(addr),
		.wdata(rx_byte),
		.raddr(addr),
		.rdata(rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_data || cmd.load_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_empty) begin
			out_byte_q  <= '0;
			frame_len_q <= '0;
			empty_q     <= 1'b1;
			last_q      <= 1'b1;
		end else if (cmd.load_data) begin
			out_byte_q  <= rd_data;
			frame_len_q <= exp_len_q;
			empty_q     <= 1'b0;
			last_q      <= (cnt_inc == exp_len_q);
		end
	end

	assign stat.sync1_hit = (rx_byte == sync_first_q);
	assign stat.sync2_hit = (rx_byte == sync_second_q);
	assign stat.len_ok    = (rx_byte <= limit);
	assign stat.rsv_hit   = (rx_byte == reserved_q);
	assign stat.len_zero  = (exp_len_q == '0);
	assign stat.cnt_last  = (cnt_inc == exp_len_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign frame_len   = frame_len_q;
	assign empty_frame = empty_q;
	assign last        = last_q;

	a_load_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_data |-> !out_valid_q)
		else $error("readout overwrote a pending beat");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_byte |-> (cnt_q < exp_len_q))
		else $error("payload write past frame length");

	a_empty_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_empty |-> (exp_len_q == '0))
		else $error("empty beat with nonzero length");

endmodule

>>> hdl/sync_length_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Byte-stream deframer: sync pair, length, reserved byte, then payload;
// completed frames are replayed byte by byte with a last marker.
// ----------------------------------------------------------------------------
// Rate: while hunting for a header and while gathering payload the block takes
// one byte per clock; the reserved byte waits for a free output register. When
// the final payload byte of a frame lands, input stalls for the readout, which
// uses the registered read port of the payload RAM (address state, then load
// state, per beat) and waits on output backpressure. A zero-length frame gives
// one beat with empty_frame set and does not stall input beyond a full output
// register. The last beat of a frame may sit in the output register while the
// next header is already being hunted. No clearing pass after reset: store
// entries are read only after being written in the same frame. Config writes
// go straight to the registers and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver
	import slfr_pkg::*;
#(
	parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	// input byte beats
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    rx_byte,
	// output payload beats
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    out_byte,
	output logic [LEN_W-1:0]     frame_len,
	output logic                 empty_frame,
	output logic                 last
);

	slfr_cmd_t  cmd;
	slfr_stat_t stat;

	// control: header hunt, payload collect, readout sequencing
	slfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// data: config regs, compares, counters, payload RAM, output register
	slfr_dp #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rx_byte    (rx_byte),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.frame_len  (frame_len),
		.empty_frame(empty_frame),
		.last       (last)
	);

endmodule

>>> tb/tb_sync_length_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_sync_length_frame_receiver
// Self-checking bench for the sync/length frame receiver. Directed header
// corner cases and register settings come first, then random frame traffic.
// The byte input idles at random and the payload output is backpressured at
// random. Every output beat is checked against a behavioral deframer.
// ----------------------------------------------------------------------------
module tb_sync_length_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	import slfr_pkg::*;

	localparam int DEPTH          = PAYLOAD_DEPTH_DEF;
	localparam int SETTLE_CYCLES  = 20;    // header bytes finish well inside this
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
	localparam int PHASE_BYTES    = 10;    // random bytes per register setting

	typedef logic [BYTE_W-1:0] byte_t;

	// hunt phases of the deframer, same coding as the block's
	typedef enum logic [2:0] {
		HUNT_SYNC1  = 3'd0,
		HUNT_SYNC2  = 3'd1,
		GET_LEN     = 3'd2,
		GET_RSV     = 3'd3,
		GET_PAYLOAD = 3'd4
	} hunt_phase_t;

	// one output beat
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
		logic              empty;
		logic              last;
	} beat_t;

	// ------------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = REG_SYNC_FIRST;
	logic [BYTE_W-1:0]    cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte     = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [BYTE_W-1:0]    out_byte;
	logic [LEN_W-1:0]     frame_len;
	logic                 empty_frame;
	logic                 last;

	sync_length_frame_receiver u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.frame_len   (frame_len),
		.empty_frame (empty_frame),
		.last        (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Deframer state and register mirror
	// ------------------------------------------------------------------------
	logic [BYTE_W-1:0] m_sync1   = SYNC_FIRST_RST;
	logic [BYTE_W-1:0] m_sync2   = SYNC_SECOND_RST;
	logic [BYTE_W-1:0] m_rsv     = RESERVED_RST;
	logic [LEN_W-1:0]  m_max_len = MAX_LEN_RST;

	hunt_phase_t       hunt      = HUNT_SYNC1;
	logic [LEN_W-1:0]  want_len  = '0;
	logic [LEN_W-1:0]  got_cnt   = '0;
	logic [BYTE_W-1:0] frame_store [DEPTH];

	beat_t pending_beats [$];   // beats owed by the block, oldest first

	int err_count      = 0;
	int bytes_sent     = 0;
	int in_burst_left  = 0;
	int out_burst_left = 0;
	int stall_left     = 0;

	// effective length limit: a register above the store depth acts as the depth
	function automatic int len_limit();
		return (int'(m_max_len) > DEPTH) ? DEPTH : int'(m_max_len);
	endfunction

	function automatic void restart_hunt();
		hunt     = HUNT_SYNC1;
		want_len = '0;
		got_cnt  = '0;
	endfunction

	// Advance the deframer by one accepted byte; queue any beats it completes.
	function automatic void deframe_byte(input byte_t b);
		beat_t bt;
		int    k;
		case (hunt)
		HUNT_SYNC1: begin
			if (b == m_sync1)
				hunt = HUNT_SYNC2;
		end
		HUNT_SYNC2: begin
			// a miss here is dropped, never retried as a first sync byte
			if (b == m_sync2)
				hunt = GET_LEN;
			else
				restart_hunt();
		end
		GET_LEN: begin
			got_cnt = '0;
			if (int'(b) > len_limit()) begin
				restart_hunt();
			end else begin
				want_len = b[LEN_W-1:0];
				hunt     = GET_RSV;
			end
		end
		GET_RSV: begin
			if (b != m_rsv) begin
				restart_hunt();
			end else if (want_len == '0) begin
				bt.data  = '0;
				bt.len   = '0;
				bt.empty = 1'b1;
				bt.last  = 1'b1;
				pending_beats.push_back(bt);
				restart_hunt();
			end else begin
				hunt = GET_PAYLOAD;
			end
		end
		GET_PAYLOAD: begin
			frame_store[got_cnt] = b;
			got_cnt = got_cnt + 1'b1;
			if (got_cnt >= want_len) begin
				// frame complete: replay the whole payload
				for (k = 0; k < int'(want_len); k++) begin
					bt.data  = frame_store[k];
					bt.len   = want_len;
					bt.empty = 1'b0;
					bt.last  = (k + 1 == int'(want_len));
					pending_beats.push_back(bt);
				end
				restart_hunt();
			end
		end
		default: restart_hunt();
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Idle pattern: mostly short gaps, a few long ones, and gap-free bursts
	// ------------------------------------------------------------------------
	function automatic int pick_idle(inout int burst_left);
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// Output backpressure: one ready cycle, then a random stall.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left = pick_idle(out_burst_left);
		end
	end

	// ------------------------------------------------------------------------
	// Byte driver. Valid is raised at a falling edge and held with the same
	// byte until a rising edge sees ready. A zero gap keeps valid high and
	// only swaps the byte, so valid is never dropped and raised in one step.
	// ------------------------------------------------------------------------
	task automatic send_byte(input byte_t b);
		int gap;
		gap = pick_idle(in_burst_left);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic send_header(input byte_t s1, input byte_t s2, input int len,
		input byte_t rsv);
		send_byte(s1);
		send_byte(s2);
		send_byte(byte_t'(len));
		send_byte(rsv);
	endtask

	task automatic send_payload(input int n);
		repeat (n) send_byte(byte_t'($urandom_range(0, 255)));
	endtask

	// Drop valid, wait for every owed beat, then let the block settle.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write, held for exactly one rising edge.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
		@(negedge clk);
		in_valid  <= 1'b0;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_SYNC_FIRST:  m_sync1   = val;
		REG_SYNC_SECOND: m_sync2   = val;
		REG_RESERVED:    m_rsv     = val;
		REG_MAX_LEN:     m_max_len = val[LEN_W-1:0];
		default: ;
		endcase
	endtask

	task automatic set_config(input byte_t s1, input byte_t s2, input byte_t rsv,
		input byte_t max_len);
		wait_idle();
		cfg_write(REG_SYNC_FIRST, s1);
		cfg_write(REG_SYNC_SECOND, s2);
		cfg_write(REG_RESERVED, rsv);
		cfg_write(REG_MAX_LEN, max_len);
	endtask

	// ------------------------------------------------------------------------
	// Output checker
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin : check_beats
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("beat with no frame pending", out_byte, 0);
			end else begin
				want = pending_beats.pop_front();
				if (out_byte !== want.data)
					report_mismatch("out_byte", out_byte, want.data);
				if (frame_len !== want.len)
					report_mismatch("frame_len", frame_len, want.len);
				if (empty_frame !== want.empty)
					report_mismatch("empty_frame", empty_frame, want.empty);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	// Watchdog: ends the run once nothing moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
		$display("[sync_length_frame_receiver] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// header with length zero: one beat flagged empty
	task automatic test_empty_frame();
		send_header(m_sync1, m_sync2, 0, m_rsv);
	endtask

	// shortest payload, all-ones data
	task automatic test_short_frame();
		send_header(m_sync1, m_sync2, 1, m_rsv);
		send_byte(8'hFF);
	endtask

	// a repeated first sync byte is a wrong second one and must not re-arm the
	// hunt; the trailing bytes would form an empty frame if it did
	task automatic test_bad_second_sync();
		send_byte(m_sync1);
		send_byte(m_sync1);
		send_byte(m_sync2);
		send_byte(8'h00);
		send_byte(m_rsv);
	endtask

	// lengths just above the limit and at the top of the byte range
	task automatic test_len_too_long();
		send_header(m_sync1, m_sync2, len_limit() + 1, m_rsv);
		send_byte(m_sync1);
		send_byte(m_sync2);
		send_byte(8'hFF);
	endtask

	task automatic test_bad_reserved();
		send_header(m_sync1, m_sync2, 0, m_rsv ^ 8'h80);
	endtask

	// zero limit, full-depth frames, and a limit register above the depth
	task automatic test_length_limit();
		set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, RESERVED_RST, 8'd0);
		send_header(m_sync1, m_sync2, 1, m_rsv);
		send_header(m_sync1, m_sync2, 0, m_rsv);
		set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, RESERVED_RST, byte_t'(MAX_LEN_RST));
		send_header(m_sync1, m_sync2, DEPTH, m_rsv);
		send_payload(DEPTH);
		// 0xFF keeps 127 in the 7-bit register, which acts as the depth
		set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, RESERVED_RST, 8'hFF);
		send_header(m_sync1, m_sync2, DEPTH + 1, m_rsv);
		send_header(m_sync1, m_sync2, DEPTH, m_rsv);
		send_payload(DEPTH);
	endtask

	// sync and reserved values at both ends of the byte range
	task automatic test_register_extremes();
		set_config(8'h00, 8'hFF, 8'hFF, 8'd1);
		send_header(m_sync1, m_sync2, 1, m_rsv);
		send_byte(8'h00);
		send_header(m_sync1, m_sync2, 0, m_rsv);
		set_config(8'hFF, 8'h00, 8'h00, byte_t'(MAX_LEN_RST));
		send_header(m_sync1, m_sync2, 2, m_rsv);
		send_payload(2);
	endtask

	// registers rewritten while a header is half received
	task automatic test_midframe_change();
		set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, RESERVED_RST, byte_t'(MAX_LEN_RST));
		send_byte(m_sync1);
		send_byte(m_sync2);
		send_byte(8'd5);
		// limit was taken with the length byte; shrinking it now changes nothing
		wait_idle();
		cfg_write(REG_MAX_LEN, 8'd0);
		// reserved byte is compared with the value at its arrival
		cfg_write(REG_RESERVED, 8'h7E);
		send_byte(8'h7E);
		send_payload(5);
		// same for the second sync byte
		wait_idle();
		send_byte(m_sync1);
		wait_idle();
		cfg_write(REG_SYNC_SECOND, 8'hC3);
		cfg_write(REG_MAX_LEN, 8'd8);
		send_byte(8'hC3);
		send_byte(8'd3);
		send_byte(m_rsv);
		send_payload(3);
	endtask

	// One random unit: mostly a well-formed frame, otherwise noise or a
	// header broken at one of its checks.
	task automatic send_random_unit();
		int r;
		int len;
		int lim;
		lim = len_limit();
		r   = $urandom_range(0, 99);
		if (r < 78) begin
			// short frames mostly, now and then anything up to the limit
			if ($urandom_range(0, 9) < 8)
				len = $urandom_range(0, (lim < 6) ? lim : 6);
			else
				len = $urandom_range(0, lim);
			send_header(m_sync1, m_sync2, len, m_rsv);
			send_payload(len);
		end else if (r < 84) begin
			repeat ($urandom_range(1, 3)) send_byte(byte_t'($urandom_range(0, 255)));
		end else if (r < 89) begin
			send_byte(m_sync1);
			send_byte(m_sync2 ^ byte_t'($urandom_range(1, 255)));
		end else if (r < 94) begin
			send_byte(m_sync1);
			send_byte(m_sync2);
			send_byte(byte_t'($urandom_range(lim + 1, 255)));
		end else begin
			send_header(m_sync1, m_sync2, $urandom_range(0, lim),
				m_rsv ^ byte_t'($urandom_range(1, 255)));
		end
	endtask

	// random traffic over a series of register settings, extremes first
	task automatic test_random_traffic();
		int start;
		for (int p = 0; p < 7; p++) begin
			case (p)
			0: set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, RESERVED_RST,
				byte_t'(MAX_LEN_RST));
			1: set_config(8'h00, 8'hFF, 8'hFF, 8'd0);
			2: set_config(8'hFF, 8'h00, 8'h80, 8'h7F);
			default: set_config(byte_t'($urandom_range(0, 255)),
				byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
				($urandom_range(0, 1) != 0) ? byte_t'($urandom_range(1, 8))
					: byte_t'($urandom_range(0, 255)));
			endcase
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES)
				send_random_unit();
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_frame();
		test_short_frame();
		test_bad_second_sync();
		test_len_too_long();
		test_bad_reserved();
		test_length_limit();
		test_register_extremes();
		test_midframe_change();
		test_random_traffic();

		wait_idle();
		if (err_count == 0) begin
			$display("[sync_length_frame_receiver] OK");
		end else begin
			$display("[sync_length_frame_receiver] ERROR");
		end
		$finish;
	end

endmodule
